>>> rtl/cpd_pkg.sv
package cpd_pkg;

    // Largest payload length accepted in a frame header
    localparam int unsigned MAX_PAYLOAD = 32;
    // Header length byte may cover id, length, payload, checksum and one code byte
    localparam logic [8:0] MAX_LEN_BYTE = 9'(MAX_PAYLOAD + 4);
    // Fewest decoded bytes a frame can hold (id, length, checksum)
    localparam logic [9:0] MIN_DECODED = 10'd3;
    // Saturation limit of the decoded byte counter
    localparam logic [8:0] COUNT_MAX = 9'h1FF;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_FULL_RUN = 8'hFF;

    // Result queue geometry
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_ERROR     = 2'd2
    } t_status;

    typedef enum logic {
        KIND_BYTE   = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  byte_value;
        logic [7:0]  byte_index;
        t_status     frame_status;
        logic [7:0]  frame_id;
        logic [7:0]  data_len;
        logic        last;
    } t_result;

endpackage

>>> rtl/cpd_if.sv
interface cpd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface cpd_res_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] byte_value;
    logic [7:0] byte_index;
    logic [1:0] frame_status;
    logic [7:0] frame_id;
    logic [7:0] data_len;
    logic       last;

    modport source (
        output valid, output kind, output byte_value, output byte_index,
        output frame_status, output frame_id, output data_len, output last,
        input ready
    );
    modport sink (
        input valid, input kind, input byte_value, input byte_index,
        input frame_status, input frame_id, input data_len, input last,
        output ready
    );
endinterface

>>> rtl/cobs_packet_deframer_unit.sv
// A result is written into the result queue when its input byte is taken and is presented from the queue head.
// Throughput: one received byte per cycle while input ready is high; each byte updates the decoder state when taken.
// The final byte of a frame can yield both a decoded byte and a status, so input ready drops
// whenever the 4-entry result queue has fewer than two free slots.
// Reset (synchronous, active low) returns to hunting for a start zero and empties the queue.
module cobs_packet_deframer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cpd_rx_if.sink     i_rx,
    cpd_res_if.source  o_res
);
    import cpd_pkg::*;

    // Decoder state
    t_phase      r_phase, n_phase;
    logic [7:0]  r_enc_left, n_enc_left;
    logic [7:0]  r_run_left, n_run_left;
    logic        r_zero_pend, n_zero_pend;
    logic [7:0]  r_xor, n_xor;
    logic [8:0]  r_count, n_count;
    logic [7:0]  r_id, n_id;
    logic [7:0]  r_len, n_len;
    logic        r_chk_done, n_chk_done;
    logic        r_chk_ok, n_chk_ok;

    // Result queue
    t_result              r_queue [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]    r_fill;

    // Results of the current byte
    t_result     res_a, res_b;
    logic [1:0]  res_num;

    logic        in_take, out_take;
    logic [7:0]  b;
    logic        emit;
    logic [7:0]  emit_val;
    logic [9:0]  need_cnt;

    assign in_take  = i_rx.valid && i_rx.ready;
    assign out_take = o_res.valid && o_res.ready;
    assign b        = i_rx.rx_byte;

    // Room for two results must exist before a byte is taken
    assign i_rx.ready = (r_fill <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));

    // Byte decode and frame checks
    always_comb begin
        n_phase     = r_phase;
        n_enc_left  = r_enc_left;
        n_run_left  = r_run_left;
        n_zero_pend = r_zero_pend;
        n_xor       = r_xor;
        n_count     = r_count;
        n_id        = r_id;
        n_len       = r_len;
        n_chk_done  = r_chk_done;
        n_chk_ok    = r_chk_ok;
        res_a       = '0;
        res_b       = '0;
        res_num     = 2'd0;
        emit        = 1'b0;
        emit_val    = BYTE_ZERO;
        need_cnt    = '0;

        unique case (r_phase)
            PH_LEN: begin
                // New frame: clear everything, then judge the length byte
                n_enc_left  = '0;
                n_run_left  = '0;
                n_zero_pend = 1'b0;
                n_xor       = '0;
                n_count     = '0;
                n_id        = '0;
                n_len       = '0;
                n_chk_done  = 1'b0;
                n_chk_ok    = 1'b0;
                if (b == BYTE_ZERO) begin
                    res_a.kind         = KIND_STATUS;
                    res_a.frame_status = ST_MALFORMED;
                    res_a.last         = 1'b1;
                    res_num            = 2'd1;
                    n_phase            = PH_LEN;
                end else if ({1'b0, b} > MAX_LEN_BYTE) begin
                    res_a.kind         = KIND_STATUS;
                    res_a.frame_status = ST_ERROR;
                    res_a.last         = 1'b1;
                    res_num            = 2'd1;
                    n_phase            = PH_HUNT;
                end else begin
                    n_enc_left = b;
                    n_phase    = PH_BODY;
                end
            end
            PH_BODY: begin
                if (b == BYTE_ZERO) begin
                    // Early zero inside the body
                    res_a.kind         = KIND_STATUS;
                    res_a.frame_status = ST_ERROR;
                    res_a.frame_id     = r_id;
                    res_a.data_len     = r_len;
                    res_a.last         = 1'b1;
                    res_num            = 2'd1;
                    n_phase            = PH_HUNT;
                end else begin
                    n_enc_left = r_enc_left - 8'd1;
                    if (r_run_left == 8'd0) begin
                        emit        = r_zero_pend;
                        emit_val    = BYTE_ZERO;
                        n_run_left  = b - 8'd1;
                        n_zero_pend = (b != BYTE_FULL_RUN);
                    end else begin
                        emit       = 1'b1;
                        emit_val   = b;
                        n_run_left = r_run_left - 8'd1;
                    end

                    // Decoded byte bookkeeping
                    if (emit) begin
                        res_a.kind       = KIND_BYTE;
                        res_a.byte_value = emit_val;
                        res_a.byte_index = r_count[7:0];
                        res_num          = 2'd1;
                        if (r_count == 9'd0) begin
                            n_id = emit_val;
                        end
                        if (r_count == 9'd1) begin
                            n_len = emit_val;
                        end
                        if (!r_chk_done) begin
                            if (r_count >= 9'd2 && r_count == {1'b0, r_len} + 9'd2) begin
                                n_chk_done = 1'b1;
                                n_chk_ok   = (r_xor == emit_val);
                            end else begin
                                n_xor = r_xor ^ emit_val;
                            end
                        end
                        if (r_count != COUNT_MAX) begin
                            n_count = r_count + 9'd1;
                        end
                    end

                    // Last encoded byte closes the frame
                    if (n_enc_left == 8'd0) begin
                        need_cnt = {2'b00, n_len} + MIN_DECODED;
                        res_b.kind     = KIND_STATUS;
                        res_b.frame_id = n_id;
                        res_b.data_len = n_len;
                        res_b.last     = 1'b1;
                        if (n_run_left != 8'd0 || {1'b0, n_count} < MIN_DECODED ||
                            {1'b0, n_count} < need_cnt) begin
                            res_b.frame_status = ST_ERROR;
                        end else if (n_chk_ok) begin
                            res_b.frame_status = ST_OK;
                        end else begin
                            res_b.frame_status = ST_MALFORMED;
                        end
                        n_phase = PH_HUNT;
                        if (emit) begin
                            res_num = 2'd2;
                        end else begin
                            res_a   = res_b;
                            res_num = 2'd1;
                        end
                    end
                end
            end
            default: begin
                // Hunting: wait for the start zero
                n_phase = (b == BYTE_ZERO) ? PH_LEN : PH_HUNT;
            end
        endcase
    end

    // Decoder state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_enc_left  <= '0;
            r_run_left  <= '0;
            r_zero_pend <= 1'b0;
            r_xor       <= '0;
            r_count     <= '0;
            r_id        <= '0;
            r_len       <= '0;
            r_chk_done  <= 1'b0;
            r_chk_ok    <= 1'b0;
        end else if (in_take) begin
            r_phase     <= n_phase;
            r_enc_left  <= n_enc_left;
            r_run_left  <= n_run_left;
            r_zero_pend <= n_zero_pend;
            r_xor       <= n_xor;
            r_count     <= n_count;
            r_id        <= n_id;
            r_len       <= n_len;
            r_chk_done  <= n_chk_done;
            r_chk_ok    <= n_chk_ok;
        end
    end

    // Result queue storage
    always_ff @(posedge i_clk) begin
        if (in_take && res_num != 2'd0) begin
            r_queue[r_wr_ptr] <= res_a;
        end
        if (in_take && res_num == 2'd2) begin
            r_queue[r_wr_ptr + QUEUE_AW'(1)] <= res_b;
        end
    end

    // Result queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (in_take) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(res_num);
            end
            if (out_take) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            r_fill <= r_fill + (in_take ? (QUEUE_AW+1)'(res_num) : '0)
                      - (QUEUE_AW+1)'(out_take);
        end
    end

    // Output transaction from the queue head
    assign o_res.valid        = (r_fill != '0);
    assign o_res.kind         = r_queue[r_rd_ptr].kind;
    assign o_res.byte_value   = r_queue[r_rd_ptr].byte_value;
    assign o_res.byte_index   = r_queue[r_rd_ptr].byte_index;
    assign o_res.frame_status = r_queue[r_rd_ptr].frame_status;
    assign o_res.frame_id     = r_queue[r_rd_ptr].frame_id;
    assign o_res.data_len     = r_queue[r_rd_ptr].data_len;
    assign o_res.last         = r_queue[r_rd_ptr].last;

endmodule
